// ===== hdl/imu_shk_pkg.sv =====
// Package for the IMU shake detector: payload structs, configuration
// register codes and fields, and shared arithmetic helpers.
// Depends on nothing; every other file imports it.
`default_nettype none

package imu_shk_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int TIME_W       = 32;
  localparam int THR_W        = 18;
  localparam int INTERVAL_W   = 16;
  localparam int HITS_W       = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  localparam int SUM_W = SAMPLE_WIDTH + 2;
  localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;

  localparam logic [THR_W-1:0]        ACCEL_THR_RESET = THR_W'(4506);
  localparam logic [THR_W-1:0]        GYRO_THR_RESET  = THR_W'(672);
  localparam logic [INTERVAL_W-1:0]   INTERVAL_RESET  = INTERVAL_W'(40);
  localparam logic [TIME_W-1:0]       COOLDOWN_RESET  = TIME_W'(2600);
  localparam logic [TIME_W-1:0]       GRACE_RESET     = '0;
  localparam logic [HITS_W-1:0]       NEEDED_RESET    = HITS_W'(2);
  localparam logic [HITS_W-1:0]       CAP_RESET       = HITS_W'(3);
  localparam logic [SAMPLE_WIDTH-1:0] ONE_G           = SAMPLE_WIDTH'(4096);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL_THR = 3'd0,
    REG_GYRO_THR  = 3'd1,
    REG_INTERVAL  = 3'd2,
    REG_COOLDOWN  = 3'd3,
    REG_GRACE_END = 3'd4,
    REG_HITS_NEED = 3'd5,
    REG_HITS_CAP  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [THR_W-1:0]      accel_delta_threshold;
    logic [THR_W-1:0]      rate_sum_threshold;
    logic [INTERVAL_W-1:0] poll_interval_ms;
    logic [TIME_W-1:0]     cooldown_ms;
    logic [TIME_W-1:0]     grace_end_ms;
    logic [HITS_W-1:0]     hits_needed;
    logic [HITS_W-1:0]     hits_cap;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]              time_ms;
    logic                           sample_ok;
    logic signed [SAMPLE_WIDTH-1:0] accel_x;
    logic signed [SAMPLE_WIDTH-1:0] accel_y;
    logic signed [SAMPLE_WIDTH-1:0] accel_z;
    logic signed [SAMPLE_WIDTH-1:0] rate_x;
    logic signed [SAMPLE_WIDTH-1:0] rate_y;
    logic signed [SAMPLE_WIDTH-1:0] rate_z;
  } sample_t;

  typedef struct packed {
    logic              sample_used;
    logic              shake_event;
    logic [HITS_W-1:0] hit_count;
  } result_t;

  function automatic logic [SAMPLE_WIDTH-1:0] abs_ext(logic signed [SAMPLE_WIDTH:0] v);
    logic signed [SAMPLE_WIDTH:0] n;
    n = -v;
    return v[SAMPLE_WIDTH] ? n[SAMPLE_WIDTH-1:0] : v[SAMPLE_WIDTH-1:0];
  endfunction

  function automatic logic [SAMPLE_WIDTH-1:0] abs_diff(logic signed [SAMPLE_WIDTH-1:0] a,
                                                       logic signed [SAMPLE_WIDTH-1:0] b);
    logic signed [SAMPLE_WIDTH:0] d;
    d = (SAMPLE_WIDTH+1)'(a) - (SAMPLE_WIDTH+1)'(b);
    return abs_ext(d);
  endfunction

  function automatic logic [SAMPLE_WIDTH-1:0] abs_val(logic signed [SAMPLE_WIDTH-1:0] a);
    return abs_ext((SAMPLE_WIDTH+1)'(a));
  endfunction

endpackage

`default_nettype wire

// ===== hdl/imu_shk_cfg.sv =====
// Configuration register bank of the IMU shake detector.
// Depends on imu_shk_pkg for register codes and the cfg_t struct.
`default_nettype none

module imu_shk_cfg
  import imu_shk_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accel_delta_threshold <= ACCEL_THR_RESET;
      cfg.rate_sum_threshold    <= GYRO_THR_RESET;
      cfg.poll_interval_ms      <= INTERVAL_RESET;
      cfg.cooldown_ms           <= COOLDOWN_RESET;
      cfg.grace_end_ms          <= GRACE_RESET;
      cfg.hits_needed           <= NEEDED_RESET;
      cfg.hits_cap              <= CAP_RESET;
    end else if (wr_en) begin
      unique case (cfg_reg_e'(wr_index))
        REG_ACCEL_THR: cfg.accel_delta_threshold <= wr_data[THR_W-1:0];
        REG_GYRO_THR:  cfg.rate_sum_threshold    <= wr_data[THR_W-1:0];
        REG_INTERVAL:  cfg.poll_interval_ms      <= wr_data[INTERVAL_W-1:0];
        REG_COOLDOWN:  cfg.cooldown_ms           <= wr_data[TIME_W-1:0];
        REG_GRACE_END: cfg.grace_end_ms          <= wr_data[TIME_W-1:0];
        REG_HITS_NEED: cfg.hits_needed           <= wr_data[HITS_W-1:0];
        REG_HITS_CAP:  cfg.hits_cap              <= wr_data[HITS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/imu_shk_core.sv =====
// Per-sample decision logic and detector state of the IMU shake detector.
// Depends on imu_shk_pkg for payload structs and abs helpers.
`default_nettype none

module imu_shk_core
  import imu_shk_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cfg_t    cfg,
  input  wire sample_t item,
  input  wire logic    commit,
  output result_t      res
);

  logic [TIME_W-1:0]              last_poll_time;
  logic [TIME_W-1:0]              last_event_time;
  logic [HITS_W-1:0]              hits;
  logic                           seeded;
  logic signed [SAMPLE_WIDTH-1:0] prev_accel_x;
  logic signed [SAMPLE_WIDTH-1:0] prev_accel_y;
  logic signed [SAMPLE_WIDTH-1:0] prev_accel_z;

  logic [TIME_W-1:0] last_poll_time_next;
  logic [TIME_W-1:0] last_event_time_next;
  logic [HITS_W-1:0] hits_next;
  logic [HITS_W-1:0] hits_step;
  logic              seeded_next;
  logic              prev_load;

  logic [SUM_W-1:0]  accel_delta;
  logic [SUM_W-1:0]  rate_sum;
  logic [TIME_W-1:0] poll_gap;
  logic [TIME_W-1:0] event_gap;
  logic              in_window;
  logic              hit;

  assign accel_delta = SUM_W'(abs_diff(item.accel_x, prev_accel_x))
                     + SUM_W'(abs_diff(item.accel_y, prev_accel_y))
                     + SUM_W'(abs_diff(item.accel_z, prev_accel_z));
  assign rate_sum    = SUM_W'(abs_val(item.rate_x))
                     + SUM_W'(abs_val(item.rate_y))
                     + SUM_W'(abs_val(item.rate_z));

  assign poll_gap  = item.time_ms - last_poll_time;
  assign event_gap = item.time_ms - last_event_time;
  assign in_window = (item.time_ms >= cfg.grace_end_ms)
                  && (poll_gap >= TIME_W'(cfg.poll_interval_ms));
  assign hit = (CMP_W'(accel_delta) > CMP_W'(cfg.accel_delta_threshold))
            || (CMP_W'(rate_sum) > CMP_W'(cfg.rate_sum_threshold));

  always_comb begin
    last_poll_time_next  = last_poll_time;
    last_event_time_next = last_event_time;
    hits_next            = hits;
    seeded_next          = seeded;
    prev_load            = 1'b0;
    res.sample_used      = 1'b0;
    res.shake_event      = 1'b0;
    hits_step            = '0;
    if (in_window) begin
      last_poll_time_next = item.time_ms;
      if (item.sample_ok) begin
        res.sample_used = 1'b1;
        prev_load       = 1'b1;
        if (!seeded) begin
          seeded_next = 1'b1;
        end else begin
          if (hit) begin
            hits_step = (hits < cfg.hits_cap) ? hits + 1'b1 : hits;
          end
          if ((hits_step >= cfg.hits_needed) && (event_gap > cfg.cooldown_ms)) begin
            last_event_time_next = item.time_ms;
            res.shake_event      = 1'b1;
            hits_next            = '0;
          end else begin
            hits_next = hits_step;
          end
        end
      end
    end
    res.hit_count = hits_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_poll_time  <= '0;
      last_event_time <= '0;
      hits            <= '0;
      seeded          <= 1'b0;
      prev_accel_x    <= '0;
      prev_accel_y    <= '0;
      prev_accel_z    <= ONE_G;
    end else if (commit) begin
      last_poll_time  <= last_poll_time_next;
      last_event_time <= last_event_time_next;
      hits            <= hits_next;
      seeded          <= seeded_next;
      if (prev_load) begin
        prev_accel_x <= item.accel_x;
        prev_accel_y <= item.accel_y;
        prev_accel_z <= item.accel_z;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/imu_shake_detector_top.sv =====
// Top level of the IMU shake detector: input register, decision core, result register.
// Depends on imu_shk_pkg, imu_shk_cfg and imu_shk_core.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-------------------------
//   sample   | sample_valid/sample_stall| sample (sample_t)
//   result   | result_valid/result_stall| result (result_t)
//   config   | cfg_valid/cfg_ready      | cfg_index, cfg_data
//
// One transaction per cycle sustained while the result side does not stall; a sample's
// result passes through the input register, then the result register.
// Detector state updates at the same edge the result register loads.
// Synchronous reset returns detector state and the config registers to their reset values and clears both valid flags.
// A stalled result stalls the sample side while the input register holds a sample.
// cfg_ready is always high.
`default_nettype none

module imu_shake_detector_top
  import imu_shk_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  sample_valid,
  output logic                       sample_stall,
  input  wire sample_t               sample,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output result_t                    result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  sample_t held;
  logic    held_valid;
  result_t step_res;
  logic    advance;
  logic    commit;

  assign cfg_ready    = 1'b1;
  assign advance      = !result_valid || !result_stall;
  assign commit       = held_valid && advance;
  assign sample_stall = held_valid && !advance;

  imu_shk_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  imu_shk_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (held),
    .commit (commit),
    .res    (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!sample_stall) begin
      held_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      held <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result <= step_res;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/imu_shk_checker.sv =====
// Port-level checker for the IMU shake detector, bound to the top level.
// Depends on imu_shk_pkg for the result struct.
`default_nettype none

module imu_shk_checker
  import imu_shk_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    sample_stall,
  input wire logic    result_valid,
  input wire logic    result_stall,
  input wire result_t result,
  input wire logic    cfg_valid,
  input wire logic    cfg_ready
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result transaction changed");

  a_event_used: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.shake_event |-> result.sample_used && result.hit_count == '0)
    else $error("event on unused sample or with nonzero hit count");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !sample_stall)
    else $error("sample side stalled with empty result register");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind imu_shake_detector_top imu_shk_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready)
);

`default_nettype wire

// ===== tb/imu_shake_detector_top_tb.sv =====
// Self-checking testbench for imu_shake_detector_top: a directed table, then randomized
// phases under several register settings, checked by table or a cycle-free predictor.
// Depends on imu_shk_pkg and the imu_shake_detector_top RTL.
`timescale 1ns / 100ps

module imu_shake_detector_top_tb;
  import imu_shk_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 9;
  localparam int NUM_PHASES   = 6;
  localparam int PHASE_ITEMS  = 250;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 6;
  localparam int TIMEOUT_NS   = 2_000_000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_kind_e;

  typedef struct {
    row_kind_e                kind;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_DATA_W-1:0]    data;
    sample_t                  smp;
    bit                       typed;
    result_t                  want;
  } stim_row_t;

  logic                  clk;
  logic                  rst          = 1'b1;
  logic                  sample_valid = 1'b0;
  logic                  sample_stall;
  sample_t               sample       = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  cfg_t model_cfg = '{ACCEL_THR_RESET, GYRO_THR_RESET, INTERVAL_RESET, COOLDOWN_RESET,
                      GRACE_RESET, NEEDED_RESET, CAP_RESET};
  logic [TIME_W-1:0]              model_last_poll  = '0;
  logic [TIME_W-1:0]              model_last_event = '0;
  logic [HITS_W-1:0]              model_hits       = '0;
  bit                             model_seeded     = 1'b0;
  logic signed [SAMPLE_WIDTH-1:0] model_prev [3]   = '{'0, '0, ONE_G};

  stim_row_t directed_rows[$];
  result_t   expected_q[$];

  int errors        = 0;
  int n_samples     = 0;
  int n_results     = 0;
  int n_events      = 0;
  int n_writes      = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_ticket   = 0;

  imu_shake_detector_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic int mag(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic result_t detect_shake(sample_t s);
    result_t           r;
    logic [TIME_W-1:0] since_poll;
    logic [TIME_W-1:0] since_event;
    int                delta;
    int                gsum;
    r = '0;
    since_poll = s.time_ms - model_last_poll;
    if (s.time_ms >= model_cfg.grace_end_ms &&
        since_poll >= TIME_W'(model_cfg.poll_interval_ms)) begin
      model_last_poll = s.time_ms;
      if (s.sample_ok) begin
        r.sample_used = 1'b1;
        if (model_seeded) begin
          delta = mag(int'(s.accel_x) - int'(model_prev[0])) +
                  mag(int'(s.accel_y) - int'(model_prev[1])) +
                  mag(int'(s.accel_z) - int'(model_prev[2]));
          gsum  = mag(int'(s.rate_x)) + mag(int'(s.rate_y)) + mag(int'(s.rate_z));
          if (delta > int'(model_cfg.accel_delta_threshold) ||
              gsum > int'(model_cfg.rate_sum_threshold)) begin
            if (model_hits < model_cfg.hits_cap) model_hits++;
          end else begin
            model_hits = '0;
          end
          since_event = s.time_ms - model_last_event;
          if (model_hits >= model_cfg.hits_needed && since_event > model_cfg.cooldown_ms) begin
            model_last_event = s.time_ms;
            model_hits       = '0;
            r.shake_event    = 1'b1;
          end
        end
        model_seeded = 1'b1;
        model_prev   = '{s.accel_x, s.accel_y, s.accel_z};
      end
    end
    r.hit_count = model_hits;
    return r;
  endfunction

  task automatic add_sample(input logic [TIME_W-1:0] t, input logic ok,
                            input int ax, input int ay, input int az,
                            input int rx, input int ry, input int rz,
                            input bit typed, input logic used, input logic ev, input int hc);
    stim_row_t row;
    row.kind  = ROW_SAMPLE;
    row.idx   = '0;
    row.data  = '0;
    row.smp   = '{t, ok, SAMPLE_WIDTH'(ax), SAMPLE_WIDTH'(ay), SAMPLE_WIDTH'(az),
                  SAMPLE_WIDTH'(rx), SAMPLE_WIDTH'(ry), SAMPLE_WIDTH'(rz)};
    row.typed = typed;
    row.want  = '{used, ev, HITS_W'(hc)};
    directed_rows.push_back(row);
  endtask

  task automatic add_config(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row.kind  = ROW_CONFIG;
    row.idx   = idx;
    row.data  = data;
    row.smp   = '0;
    row.typed = 1'b0;
    row.want  = '0;
    directed_rows.push_back(row);
  endtask

  task automatic send_sample(input sample_t s, input bit typed, input result_t want);
    result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (sample_stall);
    predicted = detect_shake(s);
    expected_q.push_back(typed ? want : predicted);
    n_samples++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ACCEL_THR: model_cfg.accel_delta_threshold = data[THR_W-1:0];
      REG_GYRO_THR:  model_cfg.rate_sum_threshold    = data[THR_W-1:0];
      REG_INTERVAL:  model_cfg.poll_interval_ms      = data[INTERVAL_W-1:0];
      REG_COOLDOWN:  model_cfg.cooldown_ms           = data[TIME_W-1:0];
      REG_GRACE_END: model_cfg.grace_end_ms          = data[TIME_W-1:0];
      REG_HITS_NEED: model_cfg.hits_needed           = data[HITS_W-1:0];
      REG_HITS_CAP:  model_cfg.hits_cap              = data[HITS_W-1:0];
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    sample_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Drive the result stall; a new hold ticket starts a long hold-off.
  initial begin : recv_drive
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_ticket) begin
        hold_seen = hold_ticket;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      n_results++;
      if (expected_q.size() == 0) begin
        errors++;
        $error("result transaction with no sample outstanding: %p", result);
      end else begin
        want = expected_q.pop_front();
        if (result.sample_used !== want.sample_used) begin
          errors++;
          $error("sample_used: expected %0d, actual %0d", want.sample_used, result.sample_used);
        end
        if (result.shake_event !== want.shake_event) begin
          errors++;
          $error("shake_event: expected %0d, actual %0d", want.shake_event, result.shake_event);
        end
        if (result.hit_count !== want.hit_count) begin
          errors++;
          $error("hit_count: expected %0d, actual %0d", want.hit_count, result.hit_count);
        end
        if (want.shake_event) n_events++;
      end
    end
  end

  initial begin : stim
    sample_t                        s;
    cfg_t                           next_cfg;
    logic [CFG_DATA_W-1:0]          junk;
    logic [TIME_W-1:0]              cur_time;
    logic signed [SAMPLE_WIDTH-1:0] cur_acc [3];
    int                             pick;
    int                             jit;
    int                             rate [3];

    add_sample(32'd0,    1'b1, 0, 0, 4096, 0, 0, 0, 1, 1'b0, 1'b0, 0);
    add_sample(32'd39,   1'b1, 0, 0, 4096, 0, 0, 0, 1, 1'b0, 1'b0, 0);
    add_sample(32'd40,   1'b0, 0, 0, 4096, 0, 0, 0, 1, 1'b0, 1'b0, 0);
    add_sample(32'd79,   1'b1, 0, 0, 4096, 0, 0, 0, 1, 1'b0, 1'b0, 0);
    add_sample(32'd80,   1'b1, 0, 0, 4096, 0, 0, 0, 1, 1'b1, 1'b0, 0);
    add_sample(32'd120,  1'b1, 32767, 0, 4096, 0, 0, 0, 1, 1'b1, 1'b0, 1);
    add_sample(32'd160,  1'b1, 32767, 0, 4096, -32768, -32768, -32768, 1, 1'b1, 1'b0, 2);
    add_sample(32'd200,  1'b1, -32768, -32768, -32768, 0, 0, 0, 1, 1'b1, 1'b0, 3);
    add_sample(32'd240,  1'b1, -32768, -32768, -32768, 32767, 0, 0, 1, 1'b1, 1'b0, 3);
    add_sample(32'd2700, 1'b1, -32768, -32768, -32768, 0, -32768, 32767, 1, 1'b1, 1'b1, 0);
    add_sample(32'd2740, 1'b1, -32768, -32768, -32768, 0, 0, 0, 1, 1'b1, 1'b0, 0);
    add_sample('1,       1'b1, -32768, -32768, -32768, 0, 0, 0, 1, 1'b1, 1'b0, 0);
    add_sample(32'd20,   1'b1, -32768, -32768, -32768, 0, 0, 0, 1, 1'b0, 1'b0, 0);
    add_sample(32'd39,   1'b1, -32768, -32768, -32768, 0, 0, 0, 1, 1'b1, 1'b0, 0);
    add_sample(32'd100,  1'b1, -28262, -32768, -32768, 672, 0, 0, 1, 1'b1, 1'b0, 0);
    add_sample(32'd140,  1'b1, -23755, -32768, -32768, 0, 0, 0, 1, 1'b1, 1'b0, 1);
    add_sample(32'd180,  1'b1, -23755, -32768, -32768, 0, 0, -673, 1, 1'b1, 1'b1, 0);
    add_config(REG_GRACE_END, '1);
    add_sample(32'd300,  1'b1, -23755, -32768, -32768, 0, 0, 0, 1, 1'b0, 1'b0, 0);
    add_sample('1,       1'b1, -23755, -32768, -32768, 0, 0, 0, 1, 1'b1, 1'b0, 0);
    add_config(REG_GRACE_END, '0);
    add_config(REG_SPARE, 32'hA5A5_5A5A);
    add_config(REG_HITS_CAP, '0);
    add_config(REG_HITS_NEED, '0);
    add_config(REG_COOLDOWN, '0);
    add_config(REG_INTERVAL, '0);
    add_sample(32'd100,  1'b1, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0, 0);
    add_sample(32'd100,  1'b1, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0, 0);
    add_sample(32'd101,  1'b0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0, 0);
    add_sample(32'd101,  1'b1, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0, 0);
    add_config(REG_HITS_CAP, 32'd15);
    add_config(REG_HITS_NEED, 32'd15);
    add_config(REG_COOLDOWN, '1);
    add_config(REG_ACCEL_THR, '0);
    add_config(REG_GYRO_THR, '0);
    add_sample(32'd102,  1'b1, 1, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0, 0);
    add_sample(32'd103,  1'b1, 1, 0, 0, 0, 0, 1, 0, 1'b0, 1'b0, 0);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG) begin
        wait_idle();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_sample(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    cur_time = 32'd1000;
    cur_acc  = '{'0, '0, ONE_G};
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph / 2)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 76;
        end
        1: begin
          send_idle_pct = 76;
          recv_idle_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      wait_idle();
      if (ph == 0) begin
        next_cfg = '{ACCEL_THR_RESET, GYRO_THR_RESET, INTERVAL_RESET, COOLDOWN_RESET,
                     GRACE_RESET, NEEDED_RESET, CAP_RESET};
      end else if (ph == 2) begin
        next_cfg = '{'0, '0, '0, '0, '0, HITS_W'(1), HITS_W'(1)};
      end else if (ph == 4) begin
        next_cfg = '{'1, '1, '1, '1, '0, '1, '1};
      end else begin
        next_cfg.accel_delta_threshold = THR_W'($urandom_range(500, 8000));
        next_cfg.rate_sum_threshold    = THR_W'($urandom_range(100, 2000));
        next_cfg.poll_interval_ms      = INTERVAL_W'($urandom_range(0, 60));
        next_cfg.cooldown_ms           = TIME_W'($urandom_range(0, 600));
        next_cfg.grace_end_ms          = ($urandom_range(0, 3) == 0) ?
                                         cur_time + $urandom_range(0, 2000) : '0;
        next_cfg.hits_needed           = HITS_W'($urandom_range(0, 4));
        next_cfg.hits_cap              = HITS_W'($urandom_range(0, 6));
      end
      junk = (ph % 2 == 1) ? CFG_DATA_W'($urandom) : '0;
      write_reg(REG_ACCEL_THR, CFG_DATA_W'({junk, next_cfg.accel_delta_threshold}));
      write_reg(REG_GYRO_THR,  CFG_DATA_W'({junk, next_cfg.rate_sum_threshold}));
      write_reg(REG_INTERVAL,  CFG_DATA_W'({junk, next_cfg.poll_interval_ms}));
      write_reg(REG_COOLDOWN,  next_cfg.cooldown_ms);
      write_reg(REG_GRACE_END, next_cfg.grace_end_ms);
      write_reg(REG_HITS_NEED, CFG_DATA_W'({junk, next_cfg.hits_needed}));
      write_reg(REG_HITS_CAP,  CFG_DATA_W'({junk, next_cfg.hits_cap}));

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 4 && k == 20) hold_ticket++;
        if (ph == 5 && k == PHASE_ITEMS / 2) wait_idle();

        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          cur_time = $urandom;
        end else if (pick < 10) begin
          cur_time += $urandom_range(0, 5000);
        end else if (pick < 30) begin
          cur_time += $urandom_range(0, 20);
        end else begin
          cur_time += $urandom_range(0, int'(model_cfg.poll_interval_ms) * 3 / 2 + 5);
        end

        for (int a = 0; a < 3; a++) begin
          pick = $urandom_range(0, 9);
          if (pick < 5) begin
            jit        = $urandom_range(0, 1000);
            cur_acc[a] = cur_acc[a] + SAMPLE_WIDTH'(jit - 500);
          end else if (pick < 8) begin
            jit        = $urandom_range(0, 32768);
            cur_acc[a] = SAMPLE_WIDTH'(jit - 16384);
          end else begin
            cur_acc[a] = SAMPLE_WIDTH'($urandom);
          end
          pick = $urandom_range(0, 9);
          if (pick < 6) begin
            jit     = $urandom_range(0, 600);
            rate[a] = jit - 300;
          end else if (pick < 9) begin
            jit     = $urandom_range(0, 4000);
            rate[a] = jit - 2000;
          end else begin
            rate[a] = $urandom;
          end
        end

        s.time_ms   = cur_time;
        s.sample_ok = ($urandom_range(0, 9) != 0);
        s.accel_x   = cur_acc[0];
        s.accel_y   = cur_acc[1];
        s.accel_z   = cur_acc[2];
        s.rate_x    = SAMPLE_WIDTH'(rate[0]);
        s.rate_y    = SAMPLE_WIDTH'(rate[1]);
        s.rate_z    = SAMPLE_WIDTH'(rate[2]);
        send_sample(s, 1'b0, '0);
      end
    end

    wait_idle();
    if (expected_q.size() != 0) begin
      errors++;
      $error("%0d expected results never arrived", expected_q.size());
    end
    $display("Run covered %0d samples, %0d results checked, %0d shake events,",
             n_samples, n_results, n_events);
    $display("  %0d register writes over %0d register settings.", n_writes, NUM_PHASES + 3);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #TIMEOUT_NS;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
